[sv/best_bid_offer_consolidator_macros.svh]
// assertion macros for the best bid offer consolidator
`ifndef BEST_BID_OFFER_CONSOLIDATOR_MACROS_SVH
`define BEST_BID_OFFER_CONSOLIDATOR_MACROS_SVH

// clocked assertion, off while in reset
`define BBOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked at the next edge
`define BBOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bboc_pkg.sv]
// types, constants and quote fold function for the best bid offer consolidator
`timescale 1ns / 1ps
package bboc_pkg;

  localparam int SYMBOL_SLOTS = 1024;
  localparam int VENUE_COUNT  = 3;
  localparam int PRICE_BITS   = 32;
  localparam int SLOT_W       = $clog2(SYMBOL_SLOTS);
  localparam int CNT_W        = $clog2(SYMBOL_SLOTS + 1);
  localparam int REC_COUNT    = SYMBOL_SLOTS * VENUE_COUNT;
  localparam int REC_W        = $clog2(REC_COUNT);
  localparam int VEN_W        = 2;

  typedef struct packed {
    logic [63:0]           symbol_key;
    logic [VEN_W-1:0]      venue_id;
    logic                  bid_present;
    logic [PRICE_BITS-1:0] bid_px;
    logic [31:0]           bid_size;
    logic                  ask_present;
    logic [PRICE_BITS-1:0] ask_px;
    logic [31:0]           ask_size;
    logic [63:0]           feed_seq;
  } bboc_in_t;

  typedef struct packed {
    logic                  quote_changed;
    logic                  best_bid_valid;
    logic [PRICE_BITS-1:0] best_bid_px;
    logic [31:0]           best_bid_size;
    logic [VEN_W-1:0]      best_bid_venue;
    logic [63:0]           best_bid_seq;
    logic                  best_ask_valid;
    logic [PRICE_BITS-1:0] best_ask_px;
    logic [31:0]           best_ask_size;
    logic [VEN_W-1:0]      best_ask_venue;
    logic [63:0]           best_ask_seq;
    logic                  table_full;
  } bboc_out_t;

  typedef struct packed {
    logic                  has_ask;
    logic                  has_bid;
    logic [PRICE_BITS-1:0] bid_px;
    logic [31:0]           bid_size;
    logic [PRICE_BITS-1:0] ask_px;
    logic [31:0]           ask_size;
    logic [63:0]           bid_seq;
    logic [63:0]           ask_seq;
  } bboc_rec_t;

  typedef struct packed {
    logic                  bid_ok;
    logic [PRICE_BITS-1:0] bid_px;
    logic [31:0]           bid_sz;
    logic [VEN_W-1:0]      bid_ven;
    logic [63:0]           bid_seq;
    logic                  ask_ok;
    logic [PRICE_BITS-1:0] ask_px;
    logic [31:0]           ask_sz;
    logic [VEN_W-1:0]      ask_ven;
    logic [63:0]           ask_seq;
  } bboc_quote_t;

  // fold one venue record into the running quote, strict compare keeps lower venue
  function automatic bboc_quote_t bboc_fold(bboc_quote_t acc, bboc_rec_t r,
                                            logic [VEN_W-1:0] v);
    bboc_quote_t q;
    q = acc;
    if (r.has_bid && (!acc.bid_ok || r.bid_px > acc.bid_px)) begin
      q.bid_ok  = 1'b1;
      q.bid_px  = r.bid_px;
      q.bid_sz  = r.bid_size;
      q.bid_ven = v;
      q.bid_seq = r.bid_seq;
    end
    if (r.has_ask && (!acc.ask_ok || r.ask_px < acc.ask_px)) begin
      q.ask_ok  = 1'b1;
      q.ask_px  = r.ask_px;
      q.ask_sz  = r.ask_size;
      q.ask_ven = v;
      q.ask_seq = r.ask_seq;
    end
    return q;
  endfunction

endpackage

[sv/best_bid_offer_consolidator.sv]
// Consolidates per-venue top-of-book updates into a best bid and best ask per symbol.
// One request at a time: the symbol table is searched one slot at a time (key memory
// read, then compare) up to the used-slot count. For a known symbol the venue records
// are then read one by one (read, then accumulate) to build the old quote across the
// 3 venues. If the venue id is valid and the symbol is known or a slot is free, the
// venue record is written (all 3 records of a new slot are initialized when it is
// allocated), and the new quote is built the same way. The result sits in an output
// register, so a new request is taken while it waits. No clearing pass: slots fill in
// order behind a count.
`timescale 1ns / 1ps
module best_bid_offer_consolidator
  import bboc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  bboc_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output bboc_out_t out_req_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_KRD     = 3'd1;
  localparam logic [2:0] S_KCMP    = 3'd2;
  localparam logic [2:0] S_QRD     = 3'd3;
  localparam logic [2:0] S_QACC    = 3'd4;
  localparam logic [2:0] S_RESOLVE = 3'd5;
  localparam logic [2:0] S_WR      = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [63:0] key_mem [SYMBOL_SLOTS];
  bboc_rec_t   rec_mem [REC_COUNT];

  logic [2:0]       state_q;
  bboc_in_t         item_q;
  logic [CNT_W-1:0] idx_q, used_q;
  logic [REC_W-1:0] base_q;
  logic [VEN_W-1:0] v_q;
  logic             pass_q, found_q, new_q, full_q;
  logic [63:0]      key_rd_q;
  bboc_rec_t        rec_rd_q;
  bboc_quote_t      acc_q, before_q;
  logic [63:0]      old_bid_seq_q, old_ask_seq_q;
  bboc_out_t        out_q;
  logic             out_valid_q;

  logic             venue_ok, last_v, key_we, rec_we;
  logic [REC_W-1:0] rec_addr;
  bboc_rec_t        wr_rec;

  assign venue_ok = item_q.venue_id < VEN_W'(VENUE_COUNT);
  assign last_v   = v_q == VEN_W'(VENUE_COUNT - 1);
  assign rec_addr = base_q + REC_W'(v_q);
  assign key_we   = (state_q == S_RESOLVE) && venue_ok && !found_q &&
                    (used_q != CNT_W'(SYMBOL_SLOTS));
  assign rec_we   = state_q == S_WR;

  always_comb begin
    wr_rec = '0;
    if (v_q == item_q.venue_id) begin
      wr_rec.has_bid  = item_q.bid_present;
      wr_rec.has_ask  = item_q.ask_present;
      wr_rec.bid_px   = item_q.bid_px;
      wr_rec.bid_size = item_q.bid_size;
      wr_rec.ask_px   = item_q.ask_px;
      wr_rec.ask_size = item_q.ask_size;
      wr_rec.bid_seq  = item_q.bid_present ? item_q.feed_seq : old_bid_seq_q;
      wr_rec.ask_seq  = item_q.ask_present ? item_q.feed_seq : old_ask_seq_q;
    end
  end

  // symbol key and venue record memories
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[used_q[SLOT_W-1:0]] <= item_q.symbol_key;
    end
    if (state_q == S_KRD) begin
      key_rd_q <= key_mem[idx_q[SLOT_W-1:0]];
    end
    if (rec_we) begin
      rec_mem[rec_addr] <= wr_rec;
    end
    if (state_q == S_QRD) begin
      rec_rd_q <= rec_mem[rec_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      item_q        <= '0;
      idx_q         <= '0;
      used_q        <= '0;
      base_q        <= '0;
      v_q           <= '0;
      pass_q        <= 1'b0;
      found_q       <= 1'b0;
      new_q         <= 1'b0;
      full_q        <= 1'b0;
      acc_q         <= '0;
      before_q      <= '0;
      old_bid_seq_q <= '0;
      old_ask_seq_q <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q        <= in_req_i;
            idx_q         <= '0;
            acc_q         <= '0;
            found_q       <= 1'b0;
            new_q         <= 1'b0;
            full_q        <= 1'b0;
            pass_q        <= 1'b0;
            old_bid_seq_q <= '0;
            old_ask_seq_q <= '0;
            state_q       <= S_KRD;
          end
        end
        S_KRD: begin
          state_q <= (idx_q == used_q) ? S_RESOLVE : S_KCMP;
        end
        S_KCMP: begin
          if (key_rd_q == item_q.symbol_key) begin
            found_q <= 1'b1;
            base_q  <= REC_W'(idx_q[SLOT_W-1:0]) * REC_W'(VENUE_COUNT);
            v_q     <= '0;
            state_q <= S_QRD;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_KRD;
          end
        end
        S_QRD: begin
          state_q <= S_QACC;
        end
        S_QACC: begin
          acc_q <= bboc_fold(acc_q, rec_rd_q, v_q);
          if (!pass_q && v_q == item_q.venue_id) begin
            old_bid_seq_q <= rec_rd_q.bid_seq;
            old_ask_seq_q <= rec_rd_q.ask_seq;
          end
          if (last_v) begin
            state_q <= pass_q ? S_DONE : S_RESOLVE;
          end else begin
            v_q     <= v_q + 1'b1;
            state_q <= S_QRD;
          end
        end
        S_RESOLVE: begin
          before_q <= acc_q;
          if (!venue_ok) begin
            state_q <= S_DONE;
          end else if (found_q) begin
            v_q     <= item_q.venue_id;
            state_q <= S_WR;
          end else if (used_q == CNT_W'(SYMBOL_SLOTS)) begin
            full_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            base_q  <= REC_W'(used_q[SLOT_W-1:0]) * REC_W'(VENUE_COUNT);
            used_q  <= used_q + 1'b1;
            new_q   <= 1'b1;
            v_q     <= '0;
            state_q <= S_WR;
          end
        end
        S_WR: begin
          if (new_q && !last_v) begin
            v_q <= v_q + 1'b1;
          end else begin
            v_q     <= '0;
            pass_q  <= 1'b1;
            acc_q   <= '0;
            state_q <= S_QRD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.quote_changed  <= pass_q && (acc_q != before_q);
            out_q.best_bid_valid <= acc_q.bid_ok;
            out_q.best_bid_px    <= acc_q.bid_px;
            out_q.best_bid_size  <= acc_q.bid_sz;
            out_q.best_bid_venue <= acc_q.bid_ven;
            out_q.best_bid_seq   <= acc_q.bid_seq;
            out_q.best_ask_valid <= acc_q.ask_ok;
            out_q.best_ask_px    <= acc_q.ask_px;
            out_q.best_ask_size  <= acc_q.ask_sz;
            out_q.best_ask_venue <= acc_q.ask_ven;
            out_q.best_ask_seq   <= acc_q.ask_seq;
            out_q.table_full     <= full_q;
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

[sv/bboc_checker.sv]
// port-level checker for the best bid offer consolidator, bound to the top level
`timescale 1ns / 1ps
`include "best_bid_offer_consolidator_macros.svh"
module bboc_checker
  import bboc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input bboc_out_t out_req_o
);

  `BBOC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `BBOC_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_req_o), "stalled result changed")
  `BBOC_ASSERT_NEXT(a_busy, in_valid_i && !in_stall_o, in_stall_o, "second request taken while busy")
  `BBOC_ASSERT(a_full_quote, out_valid_o && out_req_o.table_full |-> !out_req_o.quote_changed && !out_req_o.best_bid_valid && !out_req_o.best_ask_valid, "dropped symbol shows a quote")

endmodule

bind best_bid_offer_consolidator bboc_checker u_bboc_checker (.*);
